>>> rtl/core/enfa_pkg.sv
// Shared types, request codes and controller command encodings for the epsilon-NFA matcher.
package enfa_pkg;

   localparam int TYPE_W      = 3;
   localparam int STATE_F_W   = 4;
   localparam int SYM_W       = 8;
   localparam int MASK_OUT_W  = 16;
   localparam int STATE_EXT_W = 7;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_EPS_CHAR = 2'd0;

   localparam logic [TYPE_W-1:0] REQ_CLEAR  = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_ADD    = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_FLAGS  = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_BEGIN  = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_SYMBOL = 3'd4;

   typedef struct packed {
      logic [TYPE_W-1:0]    req_type;
      logic [STATE_F_W-1:0] from_state;
      logic [STATE_F_W-1:0] to_state;
      logic [SYM_W-1:0]     symbol;
      logic                 is_start;
      logic                 is_accepting;
   } req_item_type;

   typedef struct packed {
      logic                  accepted;
      logic                  alive;
      logic [MASK_OUT_W-1:0] active_states;
   } rsp_item_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_CAPTURE,
      OP_CLEAR_START,
      OP_CLEAR_STEP,
      OP_ADD_READ,
      OP_ADD_WRITE,
      OP_SET_FLAGS,
      OP_BEGIN,
      OP_MOVE_START,
      OP_MOVE_READ,
      OP_CLOSE_START,
      OP_CLOSE_READ,
      OP_DRAIN,
      OP_COMMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic [TYPE_W-1:0] req_code;
      logic              idx_last;
      logic              clear_last;
      logic              changed;
   } dp_status_type;

endpackage

>>> rtl/core/epsilon_nfa_string_matcher.sv
// Top level of the epsilon-NFA string matcher: register port, result register and core.
//
// Transactions on the req_ channel load the automaton (clear, add transition, set flags)
// or run it (begin string, symbol). Every transaction yields exactly one rsp_ item with
// the active set after it, whether it is nonempty and whether it holds an accepting state.
// One transaction is worked at a time; the next one is taken as soon as the result of the
// previous one sits in the output register, even while rsp_stall holds it there.
// Work per transaction, N = NUM_STATES: add transition is a read-modify-write of one
//   table row; clear wipes one move table row per cycle; symbol first reads the move
//   row of every state; begin and symbol then run P closure passes, P from 1 to N,
//   each pass reading the epsilon row of every state through one port.
// After reset the block wipes the move table with req_stall high; register writes are
// taken at any time. epsilon_char resets to zero and is compared when a transition
// is added.
module epsilon_nfa_string_matcher #(
   parameter int NUM_STATES  = 16,
   parameter int SYMBOL_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  enfa_pkg::req_item_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output enfa_pkg::rsp_item_type              rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [enfa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [enfa_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [enfa_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import enfa_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   rsp_item_type  rsp_next;
   rsp_item_type  rsp_data_ff;
   logic          rsp_valid_ff;
   logic [SYM_W-1:0] eps_char_ff;
   logic          out_free;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == CSR_EPS_CHAR) ? CSR_DATA_W'(eps_char_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_char_ff <= '0;
      end else if (csr_wr && (csr_paddr == CSR_EPS_CHAR)) begin
         eps_char_ff <= csr_pwdata[SYM_W-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   enfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd)
   );

   enfa_datapath #(
      .NUM_STATES  (NUM_STATES),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .eps_char (eps_char_ff),
      .status   (status),
      .rsp_next (rsp_next)
   );

endmodule

>>> rtl/core/enfa_datapath.sv
// Datapath: transaction register, move table and epsilon memories, state sets and sweep logic.
module enfa_datapath #(
   parameter int NUM_STATES  = 16,
   parameter int SYMBOL_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  enfa_pkg::dp_cmd_type  cmd,
   input  enfa_pkg::req_item_type req_data,
   input  logic [enfa_pkg::SYM_W-1:0] eps_char,
   output enfa_pkg::dp_status_type status,
   output enfa_pkg::rsp_item_type  rsp_next
);
   import enfa_pkg::*;

   localparam int SW       = $clog2(NUM_STATES);
   localparam int NSYM     = 1 << SYMBOL_BITS;
   localparam int MT_DEPTH = NUM_STATES * NSYM;
   localparam int MT_AW    = $clog2(MT_DEPTH);
   localparam logic [NUM_STATES-1:0] STATE_ONE = {{(NUM_STATES-1){1'b0}}, 1'b1};

   // Move table row per (state, symbol) and epsilon successor row per state.
   logic [NUM_STATES-1:0] mt_mem  [MT_DEPTH];
   logic [NUM_STATES-1:0] eps_mem [NUM_STATES];

   req_item_type          req_ff;
   logic [MT_AW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [SW-1:0]         idx_ff, idx_in;
   logic [SW-1:0]         pipe_idx_ff;
   logic                  mv_pipe_ff, cl_pipe_ff;
   logic [NUM_STATES-1:0] mt_rd_ff, eps_rd_ff;
   logic                  eps_vrd_ff;
   logic [NUM_STATES-1:0] work_ff, work_in;
   logic                  changed_ff, changed_in;
   logic [NUM_STATES-1:0] active_ff, start_ff, accept_ff, eps_valid_ff;

   logic [STATE_EXT_W-1:0] from_ext, to_ext;
   logic [SW-1:0]          from_idx, to_idx;
   logic                   from_ok, edge_ok, is_eps;
   logic [SYMBOL_BITS-1:0] sym_col;
   logic [NUM_STATES-1:0]  to_bit;
   logic [MT_AW-1:0]       mt_raddr, mt_waddr;
   logic [SW-1:0]          eps_raddr;
   logic [NUM_STATES-1:0]  mt_wdata, eps_wdata;
   logic                   mt_we, eps_we;
   logic                   mv_acc, cl_hit;
   logic [NUM_STATES+MASK_OUT_W-1:0] act_ext;

   assign from_ext = STATE_EXT_W'(req_ff.from_state);
   assign to_ext   = STATE_EXT_W'(req_ff.to_state);
   assign from_ok  = from_ext < STATE_EXT_W'(NUM_STATES);
   assign edge_ok  = from_ok && (to_ext < STATE_EXT_W'(NUM_STATES));
   assign from_idx = from_ext[SW-1:0];
   assign to_idx   = to_ext[SW-1:0];
   assign to_bit   = STATE_ONE << to_idx;
   assign sym_col  = req_ff.symbol[SYMBOL_BITS-1:0];
   // The epsilon test looks at the full label, the table column only at its low bits.
   assign is_eps   = req_ff.symbol == eps_char;

   assign mt_raddr  = (cmd.op == OP_ADD_READ) ? {from_idx, sym_col} : {idx_ff, sym_col};
   assign eps_raddr = (cmd.op == OP_ADD_READ) ? from_idx : idx_ff;

   assign mt_we    = (cmd.op == OP_CLEAR_STEP) ||
                     ((cmd.op == OP_ADD_WRITE) && edge_ok && !is_eps);
   assign mt_waddr = (cmd.op == OP_CLEAR_STEP) ? clr_cnt_ff : {from_idx, sym_col};
   assign mt_wdata = (cmd.op == OP_CLEAR_STEP) ? '0 : (mt_rd_ff | to_bit);

   assign eps_we    = (cmd.op == OP_ADD_WRITE) && edge_ok && is_eps;
   assign eps_wdata = (eps_vrd_ff ? eps_rd_ff : '0) | to_bit;

   // The registered result of each read is folded in the cycle after the read.
   assign mv_acc = mv_pipe_ff && active_ff[pipe_idx_ff];
   assign cl_hit = cl_pipe_ff && eps_vrd_ff && work_ff[pipe_idx_ff];

   always_ff @(posedge clock) begin
      mt_rd_ff <= mt_mem[mt_raddr];
      if (mt_we) begin
         mt_mem[mt_waddr] <= mt_wdata;
      end
   end

   always_ff @(posedge clock) begin
      eps_rd_ff <= eps_mem[eps_raddr];
      if (eps_we) begin
         eps_mem[from_idx] <= eps_wdata;
      end
   end

   always_comb begin
      work_in = work_ff;
      if (mv_acc) begin
         work_in = work_ff | mt_rd_ff;
      end
      if (cl_hit) begin
         work_in = work_ff | eps_rd_ff;
      end
      case (cmd.op)
         OP_MOVE_START: work_in = '0;
         OP_BEGIN:      work_in = start_ff & (~start_ff + STATE_ONE);
         default:       ;
      endcase
   end

   always_comb begin
      changed_in = changed_ff;
      if (cl_hit && ((eps_rd_ff & ~work_ff) != '0)) begin
         changed_in = 1'b1;
      end
      if ((cmd.op == OP_BEGIN) || (cmd.op == OP_CLOSE_START)) begin
         changed_in = 1'b0;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      case (cmd.op)
         OP_MOVE_START, OP_BEGIN, OP_CLOSE_START: idx_in = '0;
         OP_MOVE_READ, OP_CLOSE_READ:             idx_in = idx_ff + SW'(1);
         default:                                 ;
      endcase
   end

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      case (cmd.op)
         OP_CLEAR_START: clr_cnt_in = '0;
         OP_CLEAR_STEP:  clr_cnt_in = clr_cnt_ff + MT_AW'(1);
         default:        ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         mv_pipe_ff   <= 1'b0;
         cl_pipe_ff   <= 1'b0;
         changed_ff   <= 1'b0;
         start_ff     <= '0;
         accept_ff    <= '0;
         active_ff    <= '0;
         eps_valid_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         mv_pipe_ff <= cmd.op == OP_MOVE_READ;
         cl_pipe_ff <= cmd.op == OP_CLOSE_READ;
         changed_ff <= changed_in;
         case (cmd.op)
            OP_CLEAR_START: begin
               start_ff     <= '0;
               accept_ff    <= '0;
               active_ff    <= '0;
               eps_valid_ff <= '0;
            end
            OP_SET_FLAGS: begin
               if (from_ok) begin
                  start_ff[from_idx]  <= req_ff.is_start;
                  accept_ff[from_idx] <= req_ff.is_accepting;
               end
            end
            OP_COMMIT: active_ff <= work_ff;
            default: begin
               if (eps_we) begin
                  eps_valid_ff[from_idx] <= 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_CAPTURE) begin
         req_ff <= req_data;
      end
      idx_ff      <= idx_in;
      pipe_idx_ff <= idx_ff;
      work_ff     <= work_in;
      eps_vrd_ff  <= eps_valid_ff[eps_raddr];
   end

   assign status.req_code   = req_ff.req_type;
   assign status.idx_last   = idx_ff == SW'(NUM_STATES - 1);
   assign status.clear_last = clr_cnt_ff == MT_AW'(MT_DEPTH - 1);
   assign status.changed    = changed_ff;

   assign act_ext                = {{MASK_OUT_W{1'b0}}, active_ff};
   assign rsp_next.accepted      = (active_ff & accept_ff) != '0;
   assign rsp_next.alive         = active_ff != '0;
   assign rsp_next.active_states = act_ext[MASK_OUT_W-1:0];

endmodule

>>> rtl/core/enfa_ctrl.sv
// Controller state machine that sequences each transaction through the datapath.
module enfa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    out_free,
   input  enfa_pkg::dp_status_type status,
   output enfa_pkg::dp_cmd_type    cmd
);
   import enfa_pkg::*;

   typedef enum logic [3:0] {
      ST_WIPE,
      ST_IDLE,
      ST_DISPATCH,
      ST_CLEAR,
      ST_ADD_WRITE,
      ST_MOVE,
      ST_MOVE_TAIL,
      ST_CLOSE,
      ST_CLOSE_TAIL,
      ST_CLOSE_CHECK,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_IDLE;
      cmd.load_rsp = 1'b0;
      unique case (state_ff)
         ST_WIPE: begin
            cmd.op = OP_CLEAR_STEP;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.req_code)
               REQ_CLEAR: begin
                  cmd.op   = OP_CLEAR_START;
                  state_in = ST_CLEAR;
               end
               REQ_ADD: begin
                  cmd.op   = OP_ADD_READ;
                  state_in = ST_ADD_WRITE;
               end
               REQ_FLAGS: begin
                  cmd.op   = OP_SET_FLAGS;
                  state_in = ST_FINISH;
               end
               REQ_BEGIN: begin
                  cmd.op   = OP_BEGIN;
                  state_in = ST_CLOSE;
               end
               REQ_SYMBOL: begin
                  cmd.op   = OP_MOVE_START;
                  state_in = ST_MOVE;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_CLEAR: begin
            cmd.op = OP_CLEAR_STEP;
            if (status.clear_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_ADD_WRITE: begin
            cmd.op   = OP_ADD_WRITE;
            state_in = ST_FINISH;
         end
         ST_MOVE: begin
            cmd.op = OP_MOVE_READ;
            if (status.idx_last) begin
               state_in = ST_MOVE_TAIL;
            end
         end
         ST_MOVE_TAIL: begin
            // The last move row is folded in while the closure sweep is armed.
            cmd.op   = OP_CLOSE_START;
            state_in = ST_CLOSE;
         end
         ST_CLOSE: begin
            cmd.op = OP_CLOSE_READ;
            if (status.idx_last) begin
               state_in = ST_CLOSE_TAIL;
            end
         end
         ST_CLOSE_TAIL: begin
            cmd.op   = OP_DRAIN;
            state_in = ST_CLOSE_CHECK;
         end
         ST_CLOSE_CHECK: begin
            // A pass that added nothing means the set is closed.
            if (status.changed) begin
               cmd.op   = OP_CLOSE_START;
               state_in = ST_CLOSE;
            end else begin
               cmd.op   = OP_COMMIT;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

endmodule

>>> sim/enfa_match_checker.sv
`timescale 1ns / 100ps
// Transaction checker for the epsilon-NFA matcher: tracks the automaton and compares every result.
module enfa_match_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  enfa_pkg::req_item_type          req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  enfa_pkg::rsp_item_type          rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic                            csr_pready,
   input  logic [enfa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [enfa_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                              fail_count,
   output int                              pending_count
);
   import enfa_pkg::*;

   logic [15:0]  move_rows [0:4095];
   logic [15:0]  eps_rows [0:15];
   logic [15:0]  start_mask;
   logic [15:0]  accept_mask;
   logic [15:0]  live_set;
   logic [7:0]   eps_label;
   rsp_item_type expected_results [$];
   rsp_item_type oldest;
   int           mismatches = 0;

   assign fail_count = mismatches;

   function automatic void wipe_automaton();
      int i;
      for (i = 0; i < 4096; i++) move_rows[i] = '0;
      for (i = 0; i < 16; i++) eps_rows[i] = '0;
      start_mask  = '0;
      accept_mask = '0;
      live_set    = '0;
   endfunction

   // Sixteen rounds always reach the fixed point, so no early exit is needed.
   function automatic logic [15:0] eps_closure(input logic [15:0] seed);
      logic [15:0] cur;
      logic [15:0] grown;
      int r, s;
      cur = seed;
      for (r = 0; r < 16; r++) begin
         grown = cur;
         for (s = 0; s < 16; s++) if (cur[s]) grown |= eps_rows[s];
         cur = grown;
      end
      return cur;
   endfunction

   function automatic logic [15:0] move_on(input logic [15:0] set, input logic [7:0] sym);
      logic [15:0] nxt;
      int s;
      nxt = '0;
      for (s = 0; s < 16; s++) if (set[s]) nxt |= move_rows[{4'(s), sym}];
      return nxt;
   endfunction

   function automatic rsp_item_type apply_request(input req_item_type it);
      rsp_item_type r;
      logic [15:0]  starts;
      case (it.req_type)
         REQ_CLEAR: wipe_automaton();
         REQ_ADD: begin
            if (it.symbol == eps_label)
               eps_rows[it.from_state] |= 16'd1 << it.to_state;
            else
               move_rows[{it.from_state, it.symbol}] |= 16'd1 << it.to_state;
         end
         REQ_FLAGS: begin
            start_mask[it.from_state]  = it.is_start;
            accept_mask[it.from_state] = it.is_accepting;
         end
         REQ_BEGIN: begin
            starts   = start_mask;
            live_set = (starts != '0) ? eps_closure(starts & (~starts + 16'd1)) : '0;
         end
         REQ_SYMBOL: live_set = eps_closure(move_on(live_set, it.symbol));
         default: ;
      endcase
      r.accepted      = |(live_set & accept_mask);
      r.alive         = |live_set;
      r.active_states = live_set;
      return r;
   endfunction

   task automatic note_mismatch(input string what, input logic [15:0] want, input logic [15:0] got);
      if (mismatches < 10)
         $display("mismatch on %s: expected %h, got %h", what, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         wipe_automaton();
         eps_label = '0;
         expected_results.delete();
         pending_count <= 0;
      end else begin
         // Results are retired before new requests, since a result never belongs to a
         // request accepted at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               note_mismatch("unexpected result", '0, rsp_data.active_states);
            end else begin
               oldest = expected_results.pop_front();
               if (oldest.accepted != rsp_data.accepted)
                  note_mismatch("accepted", 16'(oldest.accepted), 16'(rsp_data.accepted));
               if (oldest.alive != rsp_data.alive)
                  note_mismatch("alive", 16'(oldest.alive), 16'(rsp_data.alive));
               if (oldest.active_states != rsp_data.active_states)
                  note_mismatch("active_states", oldest.active_states, rsp_data.active_states);
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == CSR_EPS_CHAR)
            eps_label = csr_pwdata[7:0];
         if (req_valid && !req_stall)
            expected_results.insert(expected_results.size(), apply_request(req_data));
         pending_count <= expected_results.size();
      end
   end

endmodule

>>> sim/tb_epsilon_nfa_string_matcher.sv
`timescale 1ns / 100ps
// Testbench top for the epsilon-NFA matcher: clock, reset, stimulus, register writes and verdict.
module tb_epsilon_nfa_string_matcher;
   import enfa_pkg::*;

   typedef logic [TYPE_W-1:0] req_code_type;

   localparam int CYCLE_LIMIT   = 2000000;
   localparam int ITEM_TARGET   = 1150;
   localparam int HOLD_AFTER    = 200;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 400;

   // Request codes the block does not define.
   localparam req_code_type REQ_RSVD_A = 3'd5;
   localparam req_code_type REQ_RSVD_B = 3'd6;
   localparam req_code_type REQ_RSVD_C = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_item_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_item_type          rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    pending_count;
   int                    cycle_count = 0;
   int                    counted_items = 0;
   logic                  sender_steady = 1'b0;

   epsilon_nfa_string_matcher dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   enfa_match_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result side: random stall before each transaction, steady stretches, and one long hold
   // that lets the block back up into its input.
   initial begin : rsp_side
      int   wait_n;
      int   taken;
      logic steady;
      taken  = 0;
      steady = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_AFTER) wait_n = HOLD_CYCLES;
         else if (steady) wait_n = 0;
         else wait_n = $urandom_range(0, 6);
         if (wait_n > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         taken++;
         if (taken % 48 == 0) steady = ~steady;
      end
   end

   function automatic logic [3:0] rnd4();
      return 4'($urandom_range(0, 15));
   endfunction

   function automatic logic [7:0] rnd8();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic rnd1();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic req_item_type make_item(input req_code_type code, input logic [3:0] from_s,
                                              input logic [3:0] to_s, input logic [7:0] sym,
                                              input logic st, input logic acc);
      req_item_type it;
      it.req_type     = code;
      it.from_state   = from_s;
      it.to_state     = to_s;
      it.symbol       = sym;
      it.is_start     = st;
      it.is_accepting = acc;
      return it;
   endfunction

   task automatic send_item(input req_item_type it);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (it.req_type <= REQ_SYMBOL) counted_items++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_eps_char(input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_EPS_CHAR;
      csr_pwdata  <= {24'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic run_directed();
      // Reset value of the epsilon label is zero; nothing is loaded yet.
      send_item(make_item(REQ_BEGIN, 4'd0, 4'd0, 8'h00, 1'b0, 1'b0));
      send_item(make_item(REQ_SYMBOL, 4'd0, 4'd0, 8'h41, 1'b0, 1'b0));
      send_item(make_item(REQ_ADD, 4'd0, 4'd1, 8'h00, 1'b0, 1'b0));
      send_item(make_item(REQ_ADD, 4'd0, 4'd1, 8'h00, 1'b1, 1'b1));
      send_item(make_item(REQ_ADD, 4'd1, 4'd2, 8'hFF, 1'b0, 1'b0));
      send_item(make_item(REQ_ADD, 4'd2, 4'd15, 8'h00, 1'b0, 1'b0));
      send_item(make_item(REQ_ADD, 4'd15, 4'd0, 8'hFF, 1'b0, 1'b0));
      send_item(make_item(REQ_FLAGS, 4'd3, 4'd0, 8'h00, 1'b1, 1'b1));
      send_item(make_item(REQ_FLAGS, 4'd0, 4'd15, 8'hFF, 1'b1, 1'b0));
      send_item(make_item(REQ_FLAGS, 4'd15, 4'd0, 8'h00, 1'b0, 1'b1));
      send_item(make_item(REQ_FLAGS, 4'd3, 4'd0, 8'h00, 1'b0, 1'b0));
      send_item(make_item(REQ_BEGIN, 4'd15, 4'd15, 8'hFF, 1'b1, 1'b1));
      send_item(make_item(REQ_SYMBOL, 4'd0, 4'd0, 8'hFF, 1'b0, 1'b0));
      send_item(make_item(REQ_SYMBOL, 4'd0, 4'd0, 8'hFF, 1'b0, 1'b0));
      // Stepping on the epsilon label itself only follows the move table.
      send_item(make_item(REQ_SYMBOL, 4'd0, 4'd0, 8'h00, 1'b0, 1'b0));
      send_item(make_item(REQ_RSVD_A, 4'd1, 4'd2, 8'h5A, 1'b0, 1'b1));
      send_item(make_item(REQ_RSVD_B, 4'd4, 4'd8, 8'hA5, 1'b1, 1'b0));
      send_item(make_item(REQ_RSVD_C, 4'd15, 4'd15, 8'hFF, 1'b1, 1'b1));
      send_item(make_item(REQ_CLEAR, 4'd15, 4'd15, 8'hFF, 1'b1, 1'b1));
      send_item(make_item(REQ_BEGIN, 4'd0, 4'd0, 8'h00, 1'b0, 1'b0));
      // A label is classed when the edge is added, so the edge stays epsilon after the
      // register moves on.
      wait_for_results();
      write_eps_char(8'hFF);
      send_item(make_item(REQ_ADD, 4'd4, 4'd5, 8'hFF, 1'b0, 1'b0));
      send_item(make_item(REQ_FLAGS, 4'd4, 4'd0, 8'h00, 1'b1, 1'b1));
      send_item(make_item(REQ_BEGIN, 4'd0, 4'd0, 8'h00, 1'b0, 1'b0));
      wait_for_results();
      write_eps_char(8'h00);
      send_item(make_item(REQ_ADD, 4'd5, 4'd6, 8'hFF, 1'b0, 1'b0));
      send_item(make_item(REQ_SYMBOL, 4'd0, 4'd0, 8'hFF, 1'b0, 1'b0));
      send_item(make_item(REQ_BEGIN, 4'd0, 4'd0, 8'h00, 1'b0, 1'b0));
   endtask

   task automatic run_random_phase(input int idx);
      logic [7:0] eps_now;
      logic [7:0] sym;
      logic [7:0] letters [4];
      int         n_used, n_edges, n_flags, n_strings, len, k, j, pause_at;
      wait_for_results();
      case (idx % 4)
         0: eps_now = 8'h00;
         1: eps_now = 8'hFF;
         default: eps_now = rnd8();
      endcase
      write_eps_char(eps_now);
      sender_steady = ($urandom_range(0, 2) == 0);
      if (idx == 0 || $urandom_range(0, 3) != 0)
         send_item(make_item(REQ_CLEAR, rnd4(), rnd4(), rnd8(), rnd1(), rnd1()));

      // A small alphabet and few states keep the active set alive over long strings.
      for (k = 0; k < 4; k++) letters[k] = rnd8();
      if ($urandom_range(0, 1) == 1) letters[$urandom_range(0, 3)] = eps_now;
      n_used  = $urandom_range(3, 16);
      n_edges = $urandom_range(6, 16);
      for (k = 0; k < n_edges; k++) begin
         sym = ($urandom_range(0, 3) == 0) ? eps_now : letters[$urandom_range(0, 3)];
         send_item(make_item(REQ_ADD, 4'($urandom_range(0, n_used - 1)),
                             4'($urandom_range(0, n_used - 1)), sym, rnd1(), rnd1()));
      end
      n_flags = $urandom_range(1, 4);
      for (k = 0; k < n_flags; k++)
         send_item(make_item(REQ_FLAGS, 4'($urandom_range(0, n_used - 1)), rnd4(), rnd8(),
                             rnd1(), rnd1()));
      if ($urandom_range(0, 4) != 0)
         send_item(make_item(REQ_FLAGS, 4'($urandom_range(0, n_used - 1)), rnd4(), rnd8(),
                             1'b1, rnd1()));

      n_strings = $urandom_range(3, 6);
      pause_at  = (idx == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(0, n_strings - 1)
                                                           : -1;
      for (j = 0; j < n_strings; j++) begin
         if (j == pause_at) wait_for_results();
         // Now and then a string runs on without its begin transaction.
         if ($urandom_range(0, 4) != 0)
            send_item(make_item(REQ_BEGIN, rnd4(), rnd4(), rnd8(), rnd1(), rnd1()));
         len = $urandom_range(1, 8);
         for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 11) == 0) begin
               send_item(make_item(req_code_type'($urandom_range(REQ_ADD, REQ_RSVD_C)), rnd4(),
                                   rnd4(), rnd8(), rnd1(), rnd1()));
            end else begin
               sym = ($urandom_range(0, 9) == 0) ? rnd8() : letters[$urandom_range(0, 3)];
               send_item(make_item(REQ_SYMBOL, rnd4(), rnd4(), sym, rnd1(), rnd1()));
            end
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      phase = 0;
      while (counted_items < ITEM_TARGET) begin
         run_random_phase(phase);
         phase++;
      end
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
